// ===== rtl/core/keyed_ready_queue_with_arrival_staging_top_defines.svh =====
// Assertion macros used by the checker of this block.
`ifndef KEYED_READY_QUEUE_WITH_ARRIVAL_STAGING_TOP_DEFINES_SVH
`define KEYED_READY_QUEUE_WITH_ARRIVAL_STAGING_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define KRQS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("krqs check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define KRQS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("krqs check failed");

`endif

// ===== rtl/core/krqs_pkg.sv =====
`default_nettype none
package krqs_pkg;

  localparam int unsigned READY_DEPTH_DEF = 16;
  localparam int unsigned STAGE_DEPTH_DEF = 16;

  localparam logic [2:0] FUNC_INS_LIVE  = 3'd0;
  localparam logic [2:0] FUNC_INS_STAGE = 3'd1;
  localparam logic [2:0] FUNC_POP       = 3'd2;
  localparam logic [2:0] FUNC_TICK      = 3'd3;

  localparam logic [1:0] STS_OK          = 2'd0;
  localparam logic [1:0] STS_READY_FULL  = 2'd1;
  localparam logic [1:0] STS_STAGE_FULL  = 2'd2;
  localparam logic [1:0] STS_POP_EMPTY   = 2'd3;

  localparam logic [1:0] MODE_PRIORITY = 2'd1;
  localparam logic [1:0] MODE_BURST    = 2'd2;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [7:0]  prio;
    logic [15:0] burst;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_SCAN_BEGIN,
    ST_SCAN,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic tick_chk;
    logic scan_begin;
    logic scan_step;
    logic shift_rd;
    logic shift_wr;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_pop;
    logic scan_done;
    logic best_valid;
    logic shift_more;
    logic tick_last;
  } sts_t;

  // Sort key under the current mode; the unused mode falls back to arrival.
  function automatic logic [15:0] key_of(entry_t e, logic [1:0] mode);
    logic [15:0] k;
    case (mode)
      MODE_PRIORITY: k = {8'd0, e.prio};
      MODE_BURST:    k = e.burst;
      default:       k = e.arrival;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/krqs_ram.sv =====
`default_nettype none
module krqs_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/krqs_ctrl.sv =====
`default_nettype none
module krqs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  krqs_pkg::sts_t     sts_i,
  output krqs_pkg::cmd_t     cmd_o,
  output logic               busy_o,
  output logic               result_valid_o
);
  krqs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= krqs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      krqs_pkg::ST_IDLE:       if (start_i) state_d = krqs_pkg::ST_EXEC;
      krqs_pkg::ST_EXEC:       state_d = sts_i.is_tick ? krqs_pkg::ST_TICK_RD
                                                       : krqs_pkg::ST_SCAN_BEGIN;
      krqs_pkg::ST_TICK_RD:    state_d = krqs_pkg::ST_TICK_CHK;
      krqs_pkg::ST_TICK_CHK:   state_d = sts_i.tick_last ? krqs_pkg::ST_SCAN_BEGIN
                                                         : krqs_pkg::ST_TICK_RD;
      krqs_pkg::ST_SCAN_BEGIN: state_d = krqs_pkg::ST_SCAN;
      krqs_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = (sts_i.is_pop && sts_i.best_valid) ? krqs_pkg::ST_SHIFT_RD
                                                        : krqs_pkg::ST_FINISH;
        end
      end
      krqs_pkg::ST_SHIFT_RD:   state_d = sts_i.shift_more ? krqs_pkg::ST_SHIFT_WR
                                                          : krqs_pkg::ST_FINISH;
      krqs_pkg::ST_SHIFT_WR:   state_d = krqs_pkg::ST_SHIFT_RD;
      krqs_pkg::ST_FINISH:     state_d = krqs_pkg::ST_IDLE;
      default:                 state_d = krqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    busy_o           = (state_q != krqs_pkg::ST_IDLE);
    result_valid_o   = (state_q == krqs_pkg::ST_FINISH);
    cmd_o.accept     = (state_q == krqs_pkg::ST_IDLE) && start_i;
    cmd_o.exec       = (state_q == krqs_pkg::ST_EXEC);
    cmd_o.tick_chk   = (state_q == krqs_pkg::ST_TICK_CHK);
    cmd_o.scan_begin = (state_q == krqs_pkg::ST_SCAN_BEGIN);
    cmd_o.scan_step  = (state_q == krqs_pkg::ST_SCAN);
    cmd_o.shift_rd   = (state_q == krqs_pkg::ST_SHIFT_RD);
    cmd_o.shift_wr   = (state_q == krqs_pkg::ST_SHIFT_WR);
  end
endmodule
`default_nettype wire

// ===== rtl/core/krqs_dp.sv =====
`default_nettype none
module krqs_dp #(
  parameter int unsigned READY_DEPTH = krqs_pkg::READY_DEPTH_DEF,
  parameter int unsigned STAGE_DEPTH = krqs_pkg::STAGE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  krqs_pkg::cmd_t     cmd_i,
  output krqs_pkg::sts_t     sts_o,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_data_i,
  input  wire logic [2:0]    func_i,
  input  wire logic [7:0]    proc_id_i,
  input  wire logic [15:0]   arrival_i,
  input  wire logic [7:0]    priority_req_i,
  input  wire logic [15:0]   burst_i,
  output logic      [7:0]    out_id_o,
  output logic      [15:0]   out_arrival_o,
  output logic      [7:0]    out_priority_o,
  output logic      [15:0]   out_burst_o,
  output logic               out_valid_o,
  output logic               queue_empty_o,
  output logic      [4:0]    ready_count_o,
  output logic      [15:0]   current_time_o,
  output logic      [1:0]    status_o
);
  localparam int unsigned RIW = $clog2(READY_DEPTH);
  localparam int unsigned OCW = $clog2(READY_DEPTH + 1);
  localparam int unsigned SIW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
  localparam int unsigned EW  = krqs_pkg::ENTRY_W;

  // control state
  logic [OCW-1:0]         occ_q, occ_d;
  logic [STAGE_DEPTH-1:0] svalid_q, svalid_d;
  logic [15:0]            time_q, time_d;
  logic [1:0]             mode_q;
  logic                   rv_q;
  logic                   best_valid_q, best_valid_d;

  // payload
  logic [2:0]             func_q;
  krqs_pkg::entry_t       item_q;
  krqs_pkg::entry_t       best_q, best_d;
  logic [1:0]             status_q, status_d;
  logic [OCW-1:0]         sc_q, sc_d;
  logic [OCW-1:0]         sh_q, sh_d;
  logic [RIW-1:0]         ridx_q;
  logic [SIW-1:0]         ti_q, ti_d;

  // memory ports
  logic                   r_we, s_we;
  logic [RIW-1:0]         r_waddr, r_raddr;
  logic [EW-1:0]          r_wdata, r_rdata_raw, s_rdata_raw;
  logic [SIW-1:0]         s_waddr;
  krqs_pkg::entry_t       r_rdata, s_rdata;

  logic                   issue;
  logic [OCW-1:0]         sh_inc;
  logic                   full;
  logic [SIW-1:0]         free_idx;
  logic                   free_found;
  logic                   due;

  assign r_rdata = krqs_pkg::entry_t'(r_rdata_raw);
  assign s_rdata = krqs_pkg::entry_t'(s_rdata_raw);
  assign sh_inc  = sh_q + OCW'(1);
  assign full    = (occ_q == OCW'(READY_DEPTH));
  assign issue   = cmd_i.scan_step && (sc_q < occ_q);
  assign due     = svalid_q[ti_q] && (s_rdata.arrival == time_q);

  // lowest free staging slot
  always_comb begin
    free_idx = '0;
    for (int i = STAGE_DEPTH - 1; i >= 0; i--) begin
      if (!svalid_q[i]) begin
        free_idx = SIW'(i);
      end
    end
    free_found = ~&svalid_q;
  end

  krqs_ram #(.WIDTH(EW), .DEPTH(READY_DEPTH)) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata_raw)
  );

  krqs_ram #(.WIDTH(EW), .DEPTH(STAGE_DEPTH)) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (item_q),
    .raddr_i (ti_q),
    .rdata_o (s_rdata_raw)
  );

  assign s_we    = cmd_i.exec && (func_q == krqs_pkg::FUNC_INS_STAGE) && free_found;
  assign s_waddr = free_idx;
  assign r_raddr = cmd_i.shift_rd ? sh_inc[RIW-1:0] : sc_q[RIW-1:0];

  always_comb begin
    occ_d        = occ_q;
    svalid_d     = svalid_q;
    time_d       = time_q;
    best_d       = best_q;
    best_valid_d = best_valid_q;
    status_d     = status_q;
    sc_d         = sc_q;
    sh_d         = sh_q;
    ti_d         = ti_q;
    r_we         = 1'b0;
    r_waddr      = occ_q[RIW-1:0];
    r_wdata      = item_q;

    if (cmd_i.accept) begin
      status_d = krqs_pkg::STS_OK;
      ti_d     = '0;
    end

    if (cmd_i.exec) begin
      case (func_q)
        krqs_pkg::FUNC_INS_LIVE: begin
          if (full) begin
            status_d = krqs_pkg::STS_READY_FULL;
          end else begin
            r_we  = 1'b1;
            occ_d = occ_q + OCW'(1);
          end
        end
        krqs_pkg::FUNC_INS_STAGE: begin
          if (free_found) begin
            svalid_d[free_idx] = 1'b1;
          end else begin
            status_d = krqs_pkg::STS_STAGE_FULL;
          end
        end
        krqs_pkg::FUNC_POP: begin
          if (occ_q == '0) status_d = krqs_pkg::STS_POP_EMPTY;
        end
        default: ;
      endcase
    end

    if (cmd_i.tick_chk) begin
      if (due) begin
        svalid_d[ti_q] = 1'b0;
        if (full) begin
          status_d = krqs_pkg::STS_READY_FULL;
        end else begin
          r_we    = 1'b1;
          r_wdata = s_rdata;
          occ_d   = occ_q + OCW'(1);
        end
      end
      ti_d = ti_q + SIW'(1);
      if (sts_o.tick_last && (time_q != krqs_pkg::TIME_MAX)) begin
        time_d = time_q + 16'd1;
      end
    end

    if (cmd_i.scan_begin) begin
      sc_d         = '0;
      best_valid_d = 1'b0;
    end
    if (issue) begin
      sc_d = sc_q + OCW'(1);
    end
    // strict less keeps the oldest among equal keys
    if (rv_q) begin
      if (!best_valid_q || (krqs_pkg::key_of(r_rdata, mode_q) <
                            krqs_pkg::key_of(best_q, mode_q))) begin
        best_d       = r_rdata;
        best_valid_d = 1'b1;
        sh_d         = OCW'(ridx_q);
      end
    end

    if (cmd_i.shift_rd && !sts_o.shift_more) begin
      occ_d = occ_q - OCW'(1);
    end
    if (cmd_i.shift_wr) begin
      r_we    = 1'b1;
      r_waddr = sh_q[RIW-1:0];
      r_wdata = r_rdata;
      sh_d    = sh_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q        <= '0;
      svalid_q     <= '0;
      time_q       <= '0;
      mode_q       <= '0;
      rv_q         <= 1'b0;
      best_valid_q <= 1'b0;
    end else begin
      occ_q        <= occ_d;
      svalid_q     <= svalid_d;
      time_q       <= time_d;
      rv_q         <= issue;
      best_valid_q <= best_valid_d;
      if (cfg_we_i) mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q  <= func_i;
      item_q  <= '{id: proc_id_i, arrival: arrival_i, prio: priority_req_i, burst: burst_i};
    end
    best_q   <= best_d;
    status_q <= status_d;
    sc_q     <= sc_d;
    sh_q     <= sh_d;
    ti_q     <= ti_d;
    ridx_q   <= sc_q[RIW-1:0];
  end

  always_comb begin
    sts_o.is_tick    = (func_q == krqs_pkg::FUNC_TICK);
    sts_o.is_pop     = (func_q == krqs_pkg::FUNC_POP);
    sts_o.scan_done  = !(sc_q < occ_q) && !rv_q;
    sts_o.best_valid = best_valid_q;
    sts_o.shift_more = (sh_inc < occ_q);
    sts_o.tick_last  = (ti_q == SIW'(STAGE_DEPTH - 1));
  end

  assign out_id_o       = best_valid_q ? best_q.id      : '0;
  assign out_arrival_o  = best_valid_q ? best_q.arrival : '0;
  assign out_priority_o = best_valid_q ? best_q.prio    : '0;
  assign out_burst_o    = best_valid_q ? best_q.burst   : '0;
  assign out_valid_o    = best_valid_q;
  assign queue_empty_o  = (occ_q == '0);
  assign ready_count_o  = 5'(occ_q);
  assign current_time_o = time_q;
  assign status_o       = status_q;
endmodule
`default_nettype wire

// ===== rtl/core/keyed_ready_queue_with_arrival_staging_top.sv =====
`default_nettype none
// Scheduler ready queue: entries leave in order of smallest key (arrival,
// priority or burst, picked by sort_mode); equal keys leave oldest first.
// Command channel: an item is taken on a rising edge with start high and
// busy low. func selects insert live, insert staged, pop, tick or peek.
// Every command yields exactly one result, held on the result ports for
// one cycle with result_valid_o high; the receiver cannot stall it, so the
// transfer completes on that edge.
// Config channel: cfg_valid_i/cfg_ready_o transfer sort_mode; ready is high
// whenever the block is idle.
// Command flow: the head is found by a scan of the ready RAM, one entry
// per cycle through its registered read port. A pop then shifts each
// entry behind the head down by one to close the gap. A tick first walks
// the staging RAM, reading and checking every slot, before the scan. No
// new command is taken until the result is out.
// Reset (asynchronous, active low) empties the queue, clears all staging
// slots, time and sort_mode; RAM contents are left as they are.
module keyed_ready_queue_with_arrival_staging_top #(
  parameter int unsigned READY_DEPTH = krqs_pkg::READY_DEPTH_DEF,
  parameter int unsigned STAGE_DEPTH = krqs_pkg::STAGE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_data_i,
  input  wire logic [2:0]    func_i,
  input  wire logic [7:0]    proc_id_i,
  input  wire logic [15:0]   arrival_i,
  input  wire logic [7:0]    priority_req_i,
  input  wire logic [15:0]   burst_i,
  output logic               result_valid_o,
  output logic      [7:0]    out_id_o,
  output logic      [15:0]   out_arrival_o,
  output logic      [7:0]    out_priority_o,
  output logic      [15:0]   out_burst_o,
  output logic               out_valid_o,
  output logic               queue_empty_o,
  output logic      [4:0]    ready_count_o,
  output logic      [15:0]   current_time_o,
  output logic      [1:0]    status_o
);
  krqs_pkg::cmd_t cmd;
  krqs_pkg::sts_t sts;

  // config only while idle
  assign cfg_ready_o = !busy;

  krqs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  krqs_dp #(
    .READY_DEPTH (READY_DEPTH),
    .STAGE_DEPTH (STAGE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .func_i         (func_i),
    .proc_id_i      (proc_id_i),
    .arrival_i      (arrival_i),
    .priority_req_i (priority_req_i),
    .burst_i        (burst_i),
    .out_id_o       (out_id_o),
    .out_arrival_o  (out_arrival_o),
    .out_priority_o (out_priority_o),
    .out_burst_o    (out_burst_o),
    .out_valid_o    (out_valid_o),
    .queue_empty_o  (queue_empty_o),
    .ready_count_o  (ready_count_o),
    .current_time_o (current_time_o),
    .status_o       (status_o)
  );
endmodule
`default_nettype wire

// ===== rtl/core/krqs_checker.sv =====
`default_nettype none
`include "keyed_ready_queue_with_arrival_staging_top_defines.svh"
module krqs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid_o,
  input wire logic        out_valid_o,
  input wire logic [7:0]  out_id_o,
  input wire logic        queue_empty_o,
  input wire logic [4:0]  ready_count_o
);
  `KRQS_ASSERT_NXT(a_take_busy, start && !busy, busy)
  `KRQS_ASSERT_IMP(a_res_in_cmd, result_valid_o, busy)
  `KRQS_ASSERT_NXT(a_one_result, result_valid_o, !result_valid_o && !busy)
  `KRQS_ASSERT_IMP(a_empty_cnt, result_valid_o, queue_empty_o == (ready_count_o == 5'd0))
  `KRQS_ASSERT_IMP(a_no_entry_zero, result_valid_o && !out_valid_o, out_id_o == 8'd0)
endmodule

bind keyed_ready_queue_with_arrival_staging_top krqs_checker u_krqs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .out_valid_o    (out_valid_o),
  .out_id_o       (out_id_o),
  .queue_empty_o  (queue_empty_o),
  .ready_count_o  (ready_count_o)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  // func codes and sort modes the package leaves out
  localparam logic [2:0] FUNC_PEEK      = 3'd4;
  localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
  localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
  localparam logic [2:0] FUNC_PEEK_ALT  = 3'd7;
  localparam logic [1:0] MODE_ARRIVAL   = 2'd0;
  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam int         RQ_DEPTH       = krqs_pkg::READY_DEPTH_DEF;
  localparam int         STG_DEPTH      = krqs_pkg::STAGE_DEPTH_DEF;
  // worst command: full staging walk plus a full scan, with margin
  localparam int         DRAIN_CYCLES   = 120;

  typedef struct packed {
    krqs_pkg::entry_t ent;
    logic        valid;
    logic        empty;
    logic [4:0]  count;
    logic [15:0] now;
    logic [1:0]  status;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;
  logic [2:0]  func_i = '0;
  logic [7:0]  proc_id_i = '0;
  logic [15:0] arrival_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic [15:0] burst_i = '0;
  logic        result_valid_o;
  logic [7:0]  out_id_o;
  logic [15:0] out_arrival_o;
  logic [7:0]  out_priority_o;
  logic [15:0] out_burst_o;
  logic        out_valid_o;
  logic        queue_empty_o;
  logic [4:0]  ready_count_o;
  logic [15:0] current_time_o;
  logic [1:0]  status_o;

  always #1 clk_i = ~clk_i;

  keyed_ready_queue_with_arrival_staging_top u_top (
    .clk_i, .rst_ni, .start, .busy, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .func_i, .proc_id_i, .arrival_i, .priority_req_i, .burst_i,
    .result_valid_o, .out_id_o, .out_arrival_o, .out_priority_o, .out_burst_o,
    .out_valid_o, .queue_empty_o, .ready_count_o, .current_time_o, .status_o
  );

  // ---------------------------------------------------------------
  // Scheduler model: ready list in insertion order, staging slots and
  // time, updated as each command is transferred; sort mode on config.
  // ---------------------------------------------------------------
  krqs_pkg::entry_t ready_list [RQ_DEPTH];
  int            ready_used;
  krqs_pkg::entry_t stage_slot [STG_DEPTH];
  bit            stage_busy [STG_DEPTH];
  logic [15:0]   sched_time;
  logic [1:0]    sort_sel;
  sched_result_t pending_results [$];
  int            errors;
  int            gap_pct;

  function automatic logic [15:0] sort_key(krqs_pkg::entry_t e);
    case (sort_sel)
      krqs_pkg::MODE_PRIORITY: return {8'd0, e.prio};
      krqs_pkg::MODE_BURST:    return e.burst;
      default:                 return e.arrival;
    endcase
  endfunction

  // oldest entry among those with the smallest key
  function automatic int head_slot();
    int best;
    best = 0;
    for (int i = 1; i < ready_used; i++)
      if (sort_key(ready_list[i]) < sort_key(ready_list[best])) best = i;
    return best;
  endfunction

  function automatic bit ready_push(krqs_pkg::entry_t e);
    if (ready_used >= RQ_DEPTH) return 1'b0;
    ready_list[ready_used] = e;
    ready_used++;
    return 1'b1;
  endfunction

  function automatic sched_result_t schedule_step(logic [2:0] f, krqs_pkg::entry_t e);
    sched_result_t r;
    bit            have;
    bit            placed;
    int            h;
    r = '0;
    have = 1'b0;
    r.status = krqs_pkg::STS_OK;
    case (f)
      krqs_pkg::FUNC_INS_LIVE: if (!ready_push(e)) r.status = krqs_pkg::STS_READY_FULL;
      krqs_pkg::FUNC_INS_STAGE: begin
        placed = 1'b0;
        for (int i = 0; i < STG_DEPTH && !placed; i++)
          if (!stage_busy[i]) begin
            stage_slot[i] = e;
            stage_busy[i] = 1'b1;
            placed = 1'b1;
          end
        if (!placed) r.status = krqs_pkg::STS_STAGE_FULL;
      end
      krqs_pkg::FUNC_POP: begin
        if (ready_used == 0) begin
          r.status = krqs_pkg::STS_POP_EMPTY;
        end else begin
          h = head_slot();
          r.ent = ready_list[h];
          have = 1'b1;
          for (int i = h; i + 1 < ready_used; i++) ready_list[i] = ready_list[i + 1];
          ready_used--;
        end
      end
      krqs_pkg::FUNC_TICK: begin
        // due entries go in slot order; a full ready list drops them
        for (int i = 0; i < STG_DEPTH; i++)
          if (stage_busy[i] && stage_slot[i].arrival == sched_time) begin
            stage_busy[i] = 1'b0;
            if (!ready_push(stage_slot[i])) r.status = krqs_pkg::STS_READY_FULL;
          end
        if (sched_time != krqs_pkg::TIME_MAX) sched_time++;
      end
      default: ;  // peek and spare codes change nothing
    endcase
    if (!have && ready_used > 0) begin
      r.ent = ready_list[head_slot()];
      have = 1'b1;
    end
    r.valid = have;
    r.empty = (ready_used == 0);
    r.count = ready_used[4:0];
    r.now = sched_time;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Command side. Always entered just after a rising edge. start
  // stays high when the next command follows with no gap.
  // ---------------------------------------------------------------
  task automatic send_cmd(logic [2:0] f, logic [7:0] id, logic [15:0] arr,
                          logic [7:0] pr, logic [15:0] bu);
    krqs_pkg::entry_t e;
    sched_result_t    expect_r;
    e = '{id: id, arrival: arr, prio: pr, burst: bu};
    start <= 1'b1;
    func_i <= f;
    proc_id_i <= id;
    arrival_i <= arr;
    priority_req_i <= pr;
    burst_i <= bu;
    do @(posedge clk_i); while (busy !== 1'b0);
    expect_r = schedule_step(f, e);
    pending_results = {pending_results, expect_r};
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // stop sending and let every expected result arrive
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_sort_mode(logic [1:0] m);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sort_sel = m;
  endtask

  task automatic send_live(logic [7:0] id, logic [15:0] arr, logic [7:0] pr,
                           logic [15:0] bu);
    send_cmd(krqs_pkg::FUNC_INS_LIVE, id, arr, pr, bu);
  endtask

  task automatic send_staged(logic [7:0] id, logic [15:0] arr);
    send_cmd(krqs_pkg::FUNC_INS_STAGE, id, arr, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_op(logic [2:0] f);
    // payload is don't-care for these, so drive noise on it
    send_cmd(f, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // ---------------------------------------------------------------
  // Result side: the block cannot be stalled, so every strobe is a
  // transfer and is checked against the oldest expectation.
  // ---------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_id", want.ent.id, out_id_o);
        check_field("out_arrival", want.ent.arrival, out_arrival_o);
        check_field("out_priority", want.ent.prio, out_priority_o);
        check_field("out_burst", want.ent.burst, out_burst_o);
        check_field("out_valid", want.valid, out_valid_o);
        check_field("queue_empty", want.empty, queue_empty_o);
        check_field("ready_count", want.count, ready_count_o);
        check_field("current_time", want.now, current_time_o);
        check_field("status", want.status, status_o);
      end
    end
  end

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // empty queue behavior, spare func codes, field extremes, staging basics
  task automatic test_basics();
    send_op(krqs_pkg::FUNC_POP);        // pop on empty
    send_op(FUNC_PEEK);
    send_op(FUNC_PEEK_ALT);
    send_live(8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_live(8'h00, 16'h0000, 8'h00, 16'h0000);
    send_live(8'hA5, 16'h1234, 8'h00, 16'hFFFF);
    send_live(8'h5A, 16'h1234, 8'h80, 16'h0001);  // key tie with 'hA5
    send_op(FUNC_SPARE_LO);
    send_staged(8'h01, 16'd0);          // due at the first tick
    send_staged(8'h02, krqs_pkg::TIME_MAX);  // waits for saturated time
    send_staged(8'h03, 16'd1);
    send_staged(8'h04, 16'd1);          // two due on the same tick
    send_op(krqs_pkg::FUNC_TICK);
    send_staged(8'h05, 16'd0);          // already past: never released
    send_op(krqs_pkg::FUNC_TICK);
    send_op(krqs_pkg::FUNC_TICK);
    send_op(FUNC_SPARE_MID);
    repeat (8) send_op(krqs_pkg::FUNC_POP);  // drains and pops empty again
  endtask

  // ready list overflow, live and through a tick
  task automatic test_ready_full();
    for (int i = 0; i < RQ_DEPTH + 1; i++)
      send_live(8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    send_staged(8'hC3, sched_time);
    send_op(krqs_pkg::FUNC_TICK);       // due entry finds the list full
    for (int i = 0; i < RQ_DEPTH + 1; i++) send_op(krqs_pkg::FUNC_POP);
  endtask

  // mostly well-formed traffic: inserts, staged entries due soon, pops, ticks, peeks
  task automatic test_random(int n);
    int          pick;
    logic [16:0] due;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_live(8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
      end else if (pick < 48) begin
        due = {1'b0, sched_time} + 17'($urandom_range(0, 6));
        if (due > 17'(krqs_pkg::TIME_MAX)) due = 17'(krqs_pkg::TIME_MAX);
        if (sched_time > 0 && $urandom_range(0, 99) < 2) due = 17'($urandom_range(0, 30));
        send_staged(8'($urandom), due[15:0]);
      end else if (pick < 75) begin
        send_op(krqs_pkg::FUNC_POP);
      end else if (pick < 90) begin
        send_op(krqs_pkg::FUNC_TICK);
      end else begin
        send_op(3'($urandom_range(FUNC_PEEK, FUNC_PEEK_ALT)));
      end
    end
  endtask

  // fill every staging slot with past entries, then one more
  task automatic test_stage_full();
    for (int i = 0; i < STG_DEPTH + 1; i++) send_staged(8'($urandom), 16'd0);
    send_op(krqs_pkg::FUNC_TICK);
  endtask

  initial begin
    errors = 0;
    gap_pct = 26;
    ready_used = 0;
    sched_time = '0;
    sort_sel = MODE_ARRIVAL;
    foreach (stage_busy[i]) stage_busy[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basics();
    test_ready_full();
    set_sort_mode(krqs_pkg::MODE_PRIORITY);
    test_random(250);
    // hold off until the block has returned everything
    drain_results();
    @(posedge clk_i);
    set_sort_mode(MODE_SPARE);
    gap_pct = 49;
    test_random(200);
    set_sort_mode(krqs_pkg::MODE_BURST);
    test_random(100);
    set_sort_mode(MODE_ARRIVAL);
    gap_pct = 0;
    test_random(200);
    test_stage_full();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // about 850 commands plus gaps and drains
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/krqs_pkg.sv
rtl/core/krqs_ram.sv
rtl/core/krqs_ctrl.sv
rtl/core/krqs_dp.sv
rtl/core/keyed_ready_queue_with_arrival_staging_top.sv
rtl/core/krqs_checker.sv
bench/testbench.sv
